// ----- hw/rtl/hsv2rgb_pkg.sv -----
// Package for the HSV to RGB pixel unit: field widths, sector codes,
// divisor constants and the structs passed between pipeline stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

    // Field and internal widths
    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;
    localparam int CH_W   = 8;
    localparam int RGB_W  = 3 * CH_W;
    localparam int T_W    = 6;   // ramp position 0..60
    localparam int SECT_W = 3;
    localparam int A_W    = 15;  // 255*v, up to 25500
    localparam int PZ_W   = 7;   // 100-s
    localparam int PR_W   = 13;  // s*t + 60*(100-s), up to 6000
    localparam int NR_W   = 28;  // ramp numerator, up to 153e6
    localparam int NZ_W   = 22;  // zero numerator, up to 2550000

    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
    localparam logic [HUE_W-1:0] HUE_FULL = 9'd360;

    // Divisors of the three channel formulas
    localparam int DIV_FULL = 100;
    localparam int DIV_ZERO = 10000;
    localparam int DIV_RAMP = 600000;

    // 60-degree sector codes
    localparam logic [SECT_W-1:0] SECT_RED_YEL = 3'd0;
    localparam logic [SECT_W-1:0] SECT_YEL_GRN = 3'd1;
    localparam logic [SECT_W-1:0] SECT_GRN_CYN = 3'd2;
    localparam logic [SECT_W-1:0] SECT_CYN_BLU = 3'd3;
    localparam logic [SECT_W-1:0] SECT_BLU_MAG = 3'd4;
    localparam logic [SECT_W-1:0] SECT_MAG_RED = 3'd5;

    typedef logic [SECT_W-1:0] sector_t;

    // Load enables of a two-register section
    typedef struct packed {
        logic load_a;
        logic load_b;
    } stage_en_t;

    // Output of the normalize section
    typedef struct packed {
        logic [T_W-1:0]   t;
        logic [A_W-1:0]   a;
        logic [PZ_W-1:0]  p_zero;
        logic [PCT_W-1:0] sat;
        sector_t          sector;
    } norm_t;

    // Output of the product section: three numerators and the sector
    typedef struct packed {
        logic [NR_W-1:0] n_ramp;
        logic [NZ_W-1:0] n_zero;
        logic [A_W-1:0]  n_full;
        sector_t         sector;
    } prod_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hsv2rgb_if.sv -----
// Valid/ready channel interfaces of the HSV to RGB pixel unit.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hsv2rgb_in_if
    import hsv2rgb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue_degrees;
    logic [PCT_W-1:0] saturation_pct;
    logic [PCT_W-1:0] value_pct;

    modport source (output valid, output hue_degrees, output saturation_pct,
                    output value_pct, input ready);
    modport sink   (input valid, input hue_degrees, input saturation_pct,
                    input value_pct, output ready);
endinterface

interface hsv2rgb_out_if
    import hsv2rgb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RGB_W-1:0] rgb_packed;

    modport source (output valid, output rgb_packed, input ready);
    modport sink   (input valid, input rgb_packed, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hsv_to_rgb_pixel_unit.sv -----
// Top level of the HSV to RGB pixel unit. Uses hsv2rgb_pkg, the channel
// interfaces, hsv2rgb_norm, hsv2rgb_prod and hsv2rgb_cdiv.
`timescale 1ns / 1ps
`default_nettype none

// Converts one HSV pixel (hue 0..360 degrees, saturation and value in
// percent, clamped at 100) to a packed RGB word, red in bits 23..16, green
// 15..8, blue 7..0, each channel the exact floor of 255*(channel+m). The
// unit is a seven-stage pipeline: normalize (2), products (2), constant
// dividers (2) and the output register with the sector mux (1). It takes
// one pixel per clock unless a stalled output has filled every stage.
// Each stage holds its item until the next one frees up, so a stalled
// output fills the empty stages before the input stops taking pixels;
// results come out in input order.

module hsv_to_rgb_pixel_unit
    import hsv2rgb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    hsv2rgb_in_if.sink    pix_in,
    hsv2rgb_out_if.source pix_out
);

    localparam int NSTG = 7;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] en;

    stage_en_t en_norm;
    stage_en_t en_prod;
    stage_en_t en_div;

    norm_t norm;
    prod_t prod;

    logic [CH_W-1:0] full_q;
    logic [CH_W-1:0] zero_q;
    logic [CH_W-1:0] ramp_q;

    sector_t          sect_e_reg;
    sector_t          sect_f_reg;
    logic [RGB_W-1:0] rgb_next;
    logic [RGB_W-1:0] rgb_reg;

    // Stage enables: a stage loads when it is empty or its successor loads
    always_comb
    begin
        en[NSTG-1] = !valid_reg[NSTG-1] || pix_out.ready;
        for (int i = NSTG - 2; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
    end

    assign valid_next = {valid_reg[NSTG-2:0], pix_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int i = 0; i < NSTG; i++)
                if (en[i])
                    valid_reg[i] <= valid_next[i];
        end
    end

    assign pix_in.ready = en[0];

    assign en_norm = '{load_a: en[0], load_b: en[1]};
    assign en_prod = '{load_a: en[2], load_b: en[3]};
    assign en_div  = '{load_a: en[4], load_b: en[5]};

    // Normalize and product sections
    hsv2rgb_norm u_norm (
        .clk            (clk),
        .en             (en_norm),
        .hue_degrees    (pix_in.hue_degrees),
        .saturation_pct (pix_in.saturation_pct),
        .value_pct      (pix_in.value_pct),
        .norm           (norm)
    );

    hsv2rgb_prod u_prod (
        .clk  (clk),
        .en   (en_prod),
        .norm (norm),
        .prod (prod)
    );

    // Constant dividers, one per channel kind
    hsv2rgb_cdiv #(.NW(A_W), .DIVISOR(DIV_FULL)) u_div_full (
        .clk (clk),
        .en  (en_div),
        .num (prod.n_full),
        .quo (full_q)
    );

    hsv2rgb_cdiv #(.NW(NZ_W), .DIVISOR(DIV_ZERO)) u_div_zero (
        .clk (clk),
        .en  (en_div),
        .num (prod.n_zero),
        .quo (zero_q)
    );

    hsv2rgb_cdiv #(.NW(NR_W), .DIVISOR(DIV_RAMP)) u_div_ramp (
        .clk (clk),
        .en  (en_div),
        .num (prod.n_ramp),
        .quo (ramp_q)
    );

    // Sector follows the divider stages
    always_ff @(posedge clk)
    begin
        if (en[4])
            sect_e_reg <= prod.sector;
        if (en[5])
            sect_f_reg <= sect_e_reg;
    end

    // Output stage: place chroma, ramp and zero channels by sector
    always_comb
    begin
        unique case (sect_f_reg)
            SECT_RED_YEL: rgb_next = {full_q, ramp_q, zero_q};
            SECT_YEL_GRN: rgb_next = {ramp_q, full_q, zero_q};
            SECT_GRN_CYN: rgb_next = {zero_q, full_q, ramp_q};
            SECT_CYN_BLU: rgb_next = {zero_q, ramp_q, full_q};
            SECT_BLU_MAG: rgb_next = {ramp_q, zero_q, full_q};
            default:      rgb_next = {full_q, zero_q, ramp_q};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTG-1])
            rgb_reg <= rgb_next;
    end

    assign pix_out.valid      = valid_reg[NSTG-1];
    assign pix_out.rgb_packed = rgb_reg;

`ifndef SYNTH
    // Input stalls only when every stage holds an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> (&valid_reg))
        else $error("input stalled with an empty stage");

    // Chroma >= ramp >= zero channel for every valid divider result
    a_chan_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[5] |-> ((full_q >= ramp_q) && (ramp_q >= zero_q)))
        else $error("channel ordering violated");

    // A new result only comes from a filled divider stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_out.valid) |-> $past(valid_reg[5]))
        else $error("output valid without a source item");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/hsv2rgb_norm.sv -----
// Normalize section: clamp, hue wrap, sector decode, ramp position and
// the 255*v and 100-s terms. Two register stages. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_norm
    import hsv2rgb_pkg::*;
(
    input  wire logic             clk,
    input  wire stage_en_t        en,
    input  wire logic [HUE_W-1:0] hue_degrees,
    input  wire logic [PCT_W-1:0] saturation_pct,
    input  wire logic [PCT_W-1:0] value_pct,
    output norm_t                 norm
);

    localparam logic [HUE_W-1:0] H60  = 9'd60;
    localparam logic [HUE_W-1:0] H120 = 9'd120;
    localparam logic [HUE_W-1:0] H180 = 9'd180;
    localparam logic [HUE_W-1:0] H240 = 9'd240;
    localparam logic [HUE_W-1:0] H300 = 9'd300;

    logic [PCT_W-1:0] sat_clamp;
    logic [PCT_W-1:0] val_clamp;
    logic [HUE_W-1:0] hue_wrap;
    sector_t          sect_dec;

    logic [PCT_W-1:0] sat_a_reg;
    logic [PCT_W-1:0] val_a_reg;
    logic [HUE_W-1:0] hue_a_reg;
    sector_t          sect_a_reg;

    logic [HUE_W-1:0] pos_base;
    logic [PCT_W-1:0] pos;
    norm_t            norm_next;
    norm_t            norm_reg;

    // Stage A: clamp percentages, wrap hue, pick the sector
    assign sat_clamp = (saturation_pct > PCT_MAX) ? PCT_MAX : saturation_pct;
    assign val_clamp = (value_pct > PCT_MAX) ? PCT_MAX : value_pct;
    assign hue_wrap  = (hue_degrees >= HUE_FULL) ? (hue_degrees - HUE_FULL) : hue_degrees;

    always_comb
    begin
        if (hue_wrap < H60)
            sect_dec = SECT_RED_YEL;
        else if (hue_wrap < H120)
            sect_dec = SECT_YEL_GRN;
        else if (hue_wrap < H180)
            sect_dec = SECT_GRN_CYN;
        else if (hue_wrap < H240)
            sect_dec = SECT_CYN_BLU;
        else if (hue_wrap < H300)
            sect_dec = SECT_BLU_MAG;
        else
            sect_dec = SECT_MAG_RED;
    end

    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            sat_a_reg  <= sat_clamp;
            val_a_reg  <= val_clamp;
            hue_a_reg  <= hue_wrap;
            sect_a_reg <= sect_dec;
        end
    end

    // Stage B: hue mod 120 by sector pair, fold into 0..60
    always_comb
    begin
        unique case (sect_a_reg) inside
            SECT_RED_YEL, SECT_YEL_GRN: pos_base = '0;
            SECT_GRN_CYN, SECT_CYN_BLU: pos_base = H120;
            default:                    pos_base = H240;
        endcase
    end

    assign pos = PCT_W'(hue_a_reg - pos_base);

    always_comb
    begin
        norm_next.t      = (pos >= PCT_W'(H60)) ? T_W'(PCT_W'(H120) - pos) : T_W'(pos);
        norm_next.a      = A_W'({val_a_reg, 8'b0}) - A_W'(val_a_reg);
        norm_next.p_zero = PCT_MAX - sat_a_reg;
        norm_next.sat    = sat_a_reg;
        norm_next.sector = sect_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.load_b)
            norm_reg <= norm_next;
    end

    assign norm = norm_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/hsv2rgb_prod.sv -----
// Product section: ramp weight s*t + 60*(100-s), then the numerators of
// the three channels. Two register stages. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_prod
    import hsv2rgb_pkg::*;
(
    input  wire logic      clk,
    input  wire stage_en_t en,
    input  wire norm_t     norm,
    output prod_t          prod
);

    localparam logic [PR_W-1:0] RAMP_SPAN = 13'd60;

    logic [PR_W-1:0] p_ramp_next;
    logic [NZ_W-1:0] n_zero_next;

    logic [PR_W-1:0] p_ramp_reg;
    logic [NZ_W-1:0] n_zero_reg;
    logic [A_W-1:0]  a_reg;
    sector_t         sect_c_reg;
    prod_t           prod_reg;

    // Stage C: ramp weight and zero-channel numerator
    assign p_ramp_next = PR_W'(norm.sat) * PR_W'(norm.t)
                       + PR_W'(norm.p_zero) * RAMP_SPAN;
    assign n_zero_next = NZ_W'(norm.a) * NZ_W'(norm.p_zero);

    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            p_ramp_reg <= p_ramp_next;
            n_zero_reg <= n_zero_next;
            a_reg      <= norm.a;
            sect_c_reg <= norm.sector;
        end
    end

    // Stage D: ramp numerator
    always_ff @(posedge clk)
    begin
        if (en.load_b)
        begin
            prod_reg.n_ramp <= NR_W'(a_reg) * NR_W'(p_ramp_reg);
            prod_reg.n_zero <= n_zero_reg;
            prod_reg.n_full <= a_reg;
            prod_reg.sector <= sect_c_reg;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/hsv2rgb_cdiv.sv -----
// Floor division by a constant: reciprocal multiply, then one remainder
// check and increment. Two register stages. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_cdiv
    import hsv2rgb_pkg::*;
#(
    parameter int NW      = 28,
    parameter int DIVISOR = 600000
)
(
    input  wire logic          clk,
    input  wire stage_en_t     en,
    input  wire logic [NW-1:0] num,
    output logic [CH_W-1:0]    quo
);

    // floor(2^NW/DIVISOR) underestimates the quotient by at most one
    localparam int RECIP = (1 << NW) / DIVISOR;
    localparam int RW    = $clog2(RECIP + 1);

    localparam logic [NW-1:0]    DIV_C   = NW'(DIVISOR);
    localparam logic [NW+RW-1:0] RECIP_C = (NW + RW)'(RECIP);

    logic [NW+RW-1:0] prod;
    logic [CH_W-1:0]  q0_reg;
    logic [NW-1:0]    num_reg;
    logic [NW-1:0]    q_times_d;
    logic [NW-1:0]    rem;
    logic [CH_W-1:0]  quo_reg;

    // Estimate
    assign prod = (NW + RW)'(num) * RECIP_C;

    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            q0_reg  <= prod[NW +: CH_W];
            num_reg <= num;
        end
    end

    // Correct: bump when the remainder still holds a whole divisor
    assign q_times_d = NW'(q0_reg) * DIV_C;
    assign rem       = num_reg - q_times_d;

    always_ff @(posedge clk)
    begin
        if (en.load_b)
            quo_reg <= q0_reg + CH_W'(rem >= DIV_C);
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// ----- tb/sv/hsv_to_rgb_pixel_check.sv -----
// Checker for the HSV to RGB pixel unit: watches both channels, predicts the
// packed RGB word of every pixel taken in and compares it with what comes out.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_check
    import hsv2rgb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [HUE_W-1:0] hue_degrees,
    input  logic [PCT_W-1:0] saturation_pct,
    input  logic [PCT_W-1:0] value_pct,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [RGB_W-1:0] rgb_packed,
    output int               pending,
    output int               checked,
    output int               fail_count
);

    localparam int unsigned DEG_PER_SECTOR = 60;
    localparam int unsigned CH_SCALE       = 255;
    localparam int          REPORT_MAX     = 10;

    // Expected RGB words, oldest first
    logic [RGB_W-1:0] rgb_expected_q[$];
    int               mismatches;

    // Exact integer HSV to RGB conversion
    function automatic logic [RGB_W-1:0] rgb_from_hsv(input logic [HUE_W-1:0] hue,
                                                      input logic [PCT_W-1:0] sat,
                                                      input logic [PCT_W-1:0] val);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned pos;
        int unsigned t;
        int unsigned full_ch;
        int unsigned ramp_ch;
        int unsigned zero_ch;
        sector_t     sect;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        h = 32'(hue);
        s = 32'(sat);
        v = 32'(val);
        // hue 360 and above wraps once, percentages clamp at 100
        if (h >= HUE_FULL)
            h = h - HUE_FULL;
        if (s > PCT_MAX)
            s = 32'(PCT_MAX);
        if (v > PCT_MAX)
            v = 32'(PCT_MAX);
        sect = sector_t'(h / DEG_PER_SECTOR);
        pos  = h % (2 * DEG_PER_SECTOR);
        t    = (pos >= DEG_PER_SECTOR) ? (2 * DEG_PER_SECTOR - pos) : pos;
        full_ch = (CH_SCALE * v) / DIV_FULL;
        zero_ch = (CH_SCALE * v * (PCT_MAX - s)) / DIV_ZERO;
        ramp_ch = (CH_SCALE * v * (s * t + DEG_PER_SECTOR * (PCT_MAX - s))) / DIV_RAMP;
        case (sect)
            SECT_RED_YEL:
            begin
                r = CH_W'(full_ch); g = CH_W'(ramp_ch); b = CH_W'(zero_ch);
            end
            SECT_YEL_GRN:
            begin
                r = CH_W'(ramp_ch); g = CH_W'(full_ch); b = CH_W'(zero_ch);
            end
            SECT_GRN_CYN:
            begin
                r = CH_W'(zero_ch); g = CH_W'(full_ch); b = CH_W'(ramp_ch);
            end
            SECT_CYN_BLU:
            begin
                r = CH_W'(zero_ch); g = CH_W'(ramp_ch); b = CH_W'(full_ch);
            end
            SECT_BLU_MAG:
            begin
                r = CH_W'(ramp_ch); g = CH_W'(zero_ch); b = CH_W'(full_ch);
            end
            default:
            begin
                r = CH_W'(full_ch); g = CH_W'(zero_ch); b = CH_W'(ramp_ch);
            end
        endcase
        return {r, g, b};
    endfunction

    // Compare each output transfer with the oldest expectation, then queue the new one
    always @(posedge clk)
    begin
        logic [RGB_W-1:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (rgb_expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected result rgb_packed=%06h", $realtime, rgb_packed);
                end
                else
                begin
                    want = rgb_expected_q.pop_front();
                    checked++;
                    if (rgb_packed !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: rgb_packed mismatch: expected %06h, got %06h",
                                     $realtime, want, rgb_packed);
                    end
                end
            end
            if (in_valid && in_ready)
                rgb_expected_q.push_back(rgb_from_hsv(hue_degrees, saturation_pct, value_pct));
            fail_count <= mismatches;
            pending    <= rgb_expected_q.size();
        end
    end

    // Anything still expected at the end is caught by the top via pending
endmodule

// ----- tb/sv/hsv_to_rgb_pixel_unit_test.sv -----
// Top of the HSV to RGB pixel unit testbench: clock, reset, pixel stimulus,
// output back-pressure and the verdict. Depends on hsv2rgb_pkg, the channel
// interfaces, hsv_to_rgb_pixel_check and hsv_to_rgb_pixel_unit.
`timescale 1ns / 1ps

module hsv_to_rgb_pixel_unit_test;
    import hsv2rgb_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PHASE  = 384;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   pixels_sent;
    int   quiet_cycles;
    int   pending;
    int   checked;
    int   fail_count;

    hsv2rgb_in_if  pix_in_ch();
    hsv2rgb_out_if pix_out_ch();

    hsv_to_rgb_pixel_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_ch),
        .pix_out (pix_out_ch)
    );

    hsv_to_rgb_pixel_check checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (pix_in_ch.valid),
        .in_ready       (pix_in_ch.ready),
        .hue_degrees    (pix_in_ch.hue_degrees),
        .saturation_pct (pix_in_ch.saturation_pct),
        .value_pct      (pix_in_ch.value_pct),
        .out_valid      (pix_out_ch.valid),
        .out_ready      (pix_out_ch.ready),
        .rgb_packed     (pix_out_ch.rgb_packed),
        .pending        (pending),
        .checked        (checked),
        .fail_count     (fail_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // One pixel transfer, after a random number of idle cycles
    task automatic send_pixel(input int hue, input int sat, input int val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in_ch.valid          <= 1'b1;
        pix_in_ch.hue_degrees    <= HUE_W'(hue);
        pix_in_ch.saturation_pct <= PCT_W'(sat);
        pix_in_ch.value_pct      <= PCT_W'(val);
        @(posedge clk);
        while (!pix_in_ch.ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Percent field: mostly in range, some corners, some above the clamp
    function automatic int pick_pct();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return $urandom_range(127);
        else if (sel < 25)
            return ($urandom_range(1) == 0) ? 0 : PCT_MAX;
        else
            return $urandom_range(PCT_MAX);
    endfunction

    task automatic send_random_pixel();
        int sel;
        int hue;
        sel = $urandom_range(99);
        if (sel < 70)
            hue = $urandom_range(HUE_FULL - 1);
        else if (sel < 80)
            hue = 60 * $urandom_range(6) + $urandom_range(2) - 1;   // sector borders
        else if (sel < 88)
            hue = HUE_FULL;
        else
            hue = $urandom_range(511);                              // wraps above 360
        send_pixel(hue, pick_pct(), pick_pct());
    endtask

    // Hold the sender until every queued result has come out
    task automatic wait_drained();
        pix_in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Receiver back-pressure
    initial
    begin
        pix_out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            pix_out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_in_ch.valid && pix_in_ch.ready) || (pix_out_ch.valid && pix_out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                    = 1'b0;
        pix_in_ch.valid          = 1'b0;
        pix_in_ch.hue_degrees    = '0;
        pix_in_ch.saturation_pct = '0;
        pix_in_ch.value_pct      = '0;
        send_idle_pct            = 22;
        recv_idle_pct            = 45;
        pixels_sent              = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zeros, full scale, sector borders, hue wrap, clamping
        send_pixel(0, 0, 0);
        send_pixel(0, 100, 100);
        send_pixel(30, 100, 100);
        send_pixel(59, 100, 100);
        send_pixel(60, 100, 100);
        send_pixel(61, 100, 100);
        send_pixel(119, 100, 100);
        send_pixel(120, 100, 100);
        send_pixel(180, 100, 100);
        send_pixel(240, 100, 100);
        send_pixel(300, 100, 100);
        send_pixel(359, 100, 100);
        send_pixel(360, 100, 100);
        send_pixel(361, 73, 41);
        send_pixel(511, 127, 127);
        send_pixel(90, 101, 100);
        send_pixel(210, 100, 101);
        send_pixel(270, 127, 0);
        send_pixel(150, 0, 127);
        send_pixel(330, 50, 50);
        send_pixel(256, 85, 42);
        send_pixel(45, 1, 1);
        wait_drained();

        for (int i = 0; i < RANDOM_PHASE; i++)
            send_random_pixel();
        wait_drained();

        send_idle_pct = 45;
        recv_idle_pct = 22;
        for (int i = 0; i < RANDOM_PHASE; i++)
            send_random_pixel();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RANDOM_PHASE; i++)
            send_random_pixel();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d pixels sent, %0d results compared (corners, hue wrap, clamping)",
                 pixels_sent, checked);
        $display("tb: idle patterns: slow receiver, slow sender, then back-to-back");
        if (fail_count == 0 && pending == 0 && checked == pixels_sent)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
